// ----- rtl/mqtt_rx_pkg.sv -----
// shared constants and types for the mqtt receive deframer
// no dependencies; used by mqtt_rx_packet_deframer
`default_nettype none

package mqtt_rx_pkg;

	// receive buffer size in bytes; larger packets are flagged as errors
	localparam int unsigned RX_BUFFER_BYTES = 1024;

	// smallest total packet size for a publish to pass its checks
	localparam int unsigned MIN_PUBLISH_BYTES = 5;

	// control packet types (upper nibble of the fixed header)
	localparam logic [3:0] KIND_PUBLISH = 4'd3;
	localparam logic [3:0] KIND_SUBACK  = 4'd9;

	// continuation limit of the remaining-length field
	localparam logic [2:0] MAX_LENGTH_DIGITS = 3'd4;

	// role tag carried with every byte
	typedef enum logic [2:0] {
		ROLE_HEADER    = 3'd0,
		ROLE_LENGTH    = 3'd1,
		ROLE_TOPIC_LEN = 3'd2,
		ROLE_TOPIC     = 3'd3,
		ROLE_PACKET_ID = 3'd4,
		ROLE_BODY      = 3'd5
	} role_t;

endpackage

`default_nettype wire

// ----- rtl/mqtt_rx_packet_deframer.sv -----
// mqtt 3.1.1 receive deframer: byte tagging, publish field extraction, puback requests
// depends on mqtt_rx_pkg
//
// Usage:
// - s_* is the byte input: one received stream byte per request in s_tdata.
// - m_* is the result output: every input byte yields exactly one result.
//   m_tdata carries the byte echo and the publish/ack/status fields,
//   m_tuser carries the byte role and the packet kind, m_tlast marks the
//   byte that completes a packet.
// - The result is registered: an accepted byte shows on m_* in the next cycle.
// - Throughput is one byte per cycle while m_tready is high; the per-byte parser
//   state update is a single register stage, and the result register is the only buffer.
// - When the receiver stalls, the result register holds its request and
//   s_tready drops until the result is taken; a byte is accepted in the same
//   cycle the held result leaves.
// - Reset (arst_n low) returns the parser to waiting for a fixed header and
//   clears the subscribed and error flags.
// - After a malformed length or an oversized packet, frame_error stays set
//   and all bytes are echoed as body bytes with no packet info until reset.
`default_nettype none

module mqtt_rx_packet_deframer (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input byte stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] data_byte
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata,  // [7:0] echo_byte, [8] publish_ok, [9] ack_request,
	                                   // [25:10] ack_id, [26] sub_acked, [27] frame_error
	output logic [6:0]       m_tuser,  // [2:0] byte_role, [6:3] packet_kind
	output logic             m_tlast   // packet_end
);

	// parser phases
	typedef enum logic [2:0] {
		PH_HEADER  = 3'd0,
		PH_LENGTH  = 3'd1,
		PH_TLEN_HI = 3'd2,
		PH_TLEN_LO = 3'd3,
		PH_TOPIC   = 3'd4,
		PH_ID_HI   = 3'd5,
		PH_ID_LO   = 3'd6,
		PH_BODY    = 3'd7
	} phase_t;

	// parser state
	phase_t        phase_q;
	logic [27:0]   bytes_left_q;
	logic [2:0]    digits_q;
	logic          size_ok_q;
	logic [3:0]    kind_q;
	logic [1:0]    qos_q;
	logic [15:0]   topic_size_q;
	logic [15:0]   topic_count_q;
	logic [15:0]   pkt_id_q;
	logic          sub_q;
	logic          error_q;

	// result register
	logic          out_valid_q;
	logic [7:0]    echo_q;
	mqtt_rx_pkg::role_t role_q;
	logic [3:0]    out_kind_q;
	logic          end_q;
	logic          ok_q;
	logic          ack_q;
	logic [15:0]   ack_id_q;

	// next-state and result values
	phase_t        phase_n;
	logic [27:0]   bytes_left_n;
	logic [2:0]    digits_n;
	logic          size_ok_n;
	logic [3:0]    kind_n;
	logic [1:0]    qos_n;
	logic [15:0]   topic_size_n;
	logic [15:0]   topic_count_n;
	logic [15:0]   pkt_id_n;
	logic          sub_n;
	logic          error_n;
	mqtt_rx_pkg::role_t role_c;
	logic [3:0]    kind_c;
	logic          end_c;
	logic          ok_c;
	logic          ack_c;
	logic [15:0]   ack_id_c;
	logic          done;
	logic [27:0]   digit_shifted;
	logic [28:0]   total_size;
	phase_t        after_topic;
	logic          accept;

	// handshake: take a byte whenever the result register is free or draining
	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	// next phase once the topic is complete
	assign after_topic = (qos_q != 2'd0) ? PH_ID_HI : PH_BODY;

	// remaining-length digit placed at its 7-bit position
	always_comb begin
		case (digits_q[1:0])
			2'd0:    digit_shifted = {21'd0, s_tdata[6:0]};
			2'd1:    digit_shifted = {14'd0, s_tdata[6:0], 7'd0};
			2'd2:    digit_shifted = {7'd0, s_tdata[6:0], 14'd0};
			default: digit_shifted = {s_tdata[6:0], 21'd0};
		endcase
	end

	// per-byte parser step
	always_comb begin
		phase_n       = phase_q;
		bytes_left_n  = bytes_left_q;
		digits_n      = digits_q;
		size_ok_n     = size_ok_q;
		kind_n        = kind_q;
		qos_n         = qos_q;
		topic_size_n  = topic_size_q;
		topic_count_n = topic_count_q;
		pkt_id_n      = pkt_id_q;
		sub_n         = sub_q;
		error_n       = error_q;
		role_c        = mqtt_rx_pkg::ROLE_BODY;
		kind_c        = 4'd0;
		end_c         = 1'b0;
		ok_c          = 1'b0;
		ack_c         = 1'b0;
		ack_id_c      = 16'd0;
		done          = 1'b0;
		total_size    = 29'd0;

		if (!error_q) begin
			kind_c = kind_q;
			unique case (phase_q)
				PH_HEADER: begin
					kind_n        = s_tdata[7:4];
					qos_n         = s_tdata[2:1];
					topic_size_n  = 16'd0;
					topic_count_n = 16'd0;
					pkt_id_n      = 16'd0;
					digits_n      = 3'd0;
					bytes_left_n  = 28'd0;
					size_ok_n     = 1'b0;
					kind_c        = s_tdata[7:4];
					role_c        = mqtt_rx_pkg::ROLE_HEADER;
					phase_n       = PH_LENGTH;
				end
				PH_LENGTH: begin
					role_c       = mqtt_rx_pkg::ROLE_LENGTH;
					bytes_left_n = bytes_left_q | digit_shifted;
					digits_n     = digits_q + 3'd1;
					if (s_tdata[7]) begin
						if (digits_n >= mqtt_rx_pkg::MAX_LENGTH_DIGITS) begin
							error_n = 1'b1;
						end
					end else begin
						total_size = 29'd1 + {26'd0, digits_n} + {1'b0, bytes_left_n};
						size_ok_n  = total_size >= 29'(mqtt_rx_pkg::MIN_PUBLISH_BYTES);
						if (total_size > 29'(mqtt_rx_pkg::RX_BUFFER_BYTES)) begin
							error_n = 1'b1;
						end else if (bytes_left_n == 28'd0) begin
							done = 1'b1;
						end else if (kind_q == mqtt_rx_pkg::KIND_PUBLISH) begin
							phase_n = PH_TLEN_HI;
						end else begin
							phase_n = PH_BODY;
						end
					end
				end
				default: begin
					// variable header and body bytes
					case (phase_q)
						PH_TLEN_HI: begin
							role_c       = mqtt_rx_pkg::ROLE_TOPIC_LEN;
							topic_size_n = {s_tdata, 8'd0};
							phase_n      = PH_TLEN_LO;
						end
						PH_TLEN_LO: begin
							role_c        = mqtt_rx_pkg::ROLE_TOPIC_LEN;
							topic_size_n  = topic_size_q | {8'd0, s_tdata};
							topic_count_n = 16'd0;
							if (topic_size_n != 16'd0) begin
								phase_n = PH_TOPIC;
							end else begin
								phase_n = after_topic;
							end
						end
						PH_TOPIC: begin
							role_c        = mqtt_rx_pkg::ROLE_TOPIC;
							topic_count_n = topic_count_q + 16'd1;
							if (topic_count_n >= topic_size_q) begin
								phase_n = after_topic;
							end
						end
						PH_ID_HI: begin
							role_c   = mqtt_rx_pkg::ROLE_PACKET_ID;
							pkt_id_n = {s_tdata, 8'd0};
							phase_n  = PH_ID_LO;
						end
						PH_ID_LO: begin
							role_c   = mqtt_rx_pkg::ROLE_PACKET_ID;
							pkt_id_n = pkt_id_q | {8'd0, s_tdata};
							phase_n  = PH_BODY;
						end
						default: begin
							role_c = mqtt_rx_pkg::ROLE_BODY;
						end
					endcase
					if (bytes_left_q != 28'd0) begin
						bytes_left_n = bytes_left_q - 28'd1;
					end
					if (bytes_left_n == 28'd0) begin
						done = 1'b1;
					end
				end
			endcase

			// packet completion
			if (done) begin
				end_c = 1'b1;
				if (kind_q == mqtt_rx_pkg::KIND_PUBLISH) begin
					ok_c     = size_ok_n && (phase_n == PH_ID_HI || phase_n == PH_ID_LO
						|| phase_n == PH_BODY);
					ack_c    = ok_c && (qos_q == 2'd1);
					ack_id_c = ack_c ? pkt_id_n : 16'd0;
				end
				if (kind_q == mqtt_rx_pkg::KIND_SUBACK) begin
					sub_n = 1'b1;
				end
				phase_n = PH_HEADER;
			end
		end
	end

	// parser state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_HEADER;
			bytes_left_q  <= 28'd0;
			digits_q      <= 3'd0;
			size_ok_q     <= 1'b0;
			kind_q        <= 4'd0;
			qos_q         <= 2'd0;
			topic_size_q  <= 16'd0;
			topic_count_q <= 16'd0;
			pkt_id_q      <= 16'd0;
			sub_q         <= 1'b0;
			error_q       <= 1'b0;
		end else if (accept) begin
			phase_q       <= phase_n;
			bytes_left_q  <= bytes_left_n;
			digits_q      <= digits_n;
			size_ok_q     <= size_ok_n;
			kind_q        <= kind_n;
			qos_q         <= qos_n;
			topic_size_q  <= topic_size_n;
			topic_count_q <= topic_count_n;
			pkt_id_q      <= pkt_id_n;
			sub_q         <= sub_n;
			error_q       <= error_n;
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			echo_q     <= s_tdata;
			role_q     <= role_c;
			out_kind_q <= kind_c;
			end_q      <= end_c;
			ok_q       <= ok_c;
			ack_q      <= ack_c;
			ack_id_q   <= ack_id_c;
		end
	end

	// output packing; status flags follow the state after the byte
	logic sub_out_q;
	logic err_out_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			sub_out_q <= sub_n;
			err_out_q <= error_n;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {4'd0, err_out_q, sub_out_q, ack_id_q, ack_q, ok_q, echo_q};
	assign m_tuser  = {out_kind_q, role_q};
	assign m_tlast  = end_q;

endmodule

`default_nettype wire
